FILE: sv/assert_macros.svh
// Assertion macros shared by the Gaussian pair generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define BMG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define BMG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bmg_pkg.sv
// Types and constants of the Box-Muller Gaussian pair generator.
package bmg_pkg;

  localparam int unsigned LogSteps = 30;
  localparam int unsigned TrigSteps = 4;

  localparam logic [30:0] Q30One = 31'd1073741824;
  localparam logic [30:0] TwoLn2Q30 = 31'd1488522236;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;

  localparam logic [63:0] RecipS72 = ((64'd1 << 37) + 64'd71) / 64'd72;
  localparam logic [63:0] RecipS42 = ((64'd1 << 36) + 64'd41) / 64'd42;
  localparam logic [63:0] RecipS20 = ((64'd1 << 35) + 64'd19) / 64'd20;
  localparam logic [63:0] RecipS6 = ((64'd1 << 33) + 64'd5) / 64'd6;
  localparam logic [63:0] RecipC90 = ((64'd1 << 37) + 64'd89) / 64'd90;
  localparam logic [63:0] RecipC56 = ((64'd1 << 36) + 64'd55) / 64'd56;
  localparam logic [63:0] RecipC30 = ((64'd1 << 35) + 64'd29) / 64'd30;
  localparam logic [63:0] RecipC12 = ((64'd1 << 34) + 64'd11) / 64'd12;

  localparam logic [30:0] RecipSin [TrigSteps] = '{
    RecipS72[30:0], RecipS42[30:0], RecipS20[30:0], RecipS6[30:0]};
  localparam logic [30:0] RecipCos [TrigSteps] = '{
    RecipC90[30:0], RecipC56[30:0], RecipC30[30:0], RecipC12[30:0]};
  localparam int unsigned ShiftSin [TrigSteps] = '{37, 36, 35, 33};
  localparam int unsigned ShiftCos [TrigSteps] = '{37, 36, 35, 34};

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
  } trig_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] quad;
    logic       swap;
  } side_t;

endpackage

FILE: sv/box_muller_gaussian.sv
// Top level of the Box-Muller Gaussian pair generator.
//
//  port group  dir  tdata (low bit up)            tuser
//  s_axis      in   u_radius[31:0], u_angle[31:0]  -
//  m_axis      out  gauss_cos[15:0], gauss_sin      out_of_range
//
// One transfer in and one out per cycle while m_axis takes results; the row's length is set
// by the 30 logarithm cells and one square-root cell per bit.
// The whole row advances together; it holds while a result waits at m_axis.
// Reset clears the valid bits only.
`include "assert_macros.svh"

module box_muller_gaussian #(
  parameter int unsigned IN_FRAC_BITS = 32,
  parameter int unsigned OUT_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // u_radius, u_angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // gauss_cos, gauss_sin
  output logic        m_axis_tuser    // out_of_range
);

  localparam int unsigned HiW = $clog2(IN_FRAC_BITS + 1);
  localparam int unsigned RW = HiW + 32;
  localparam int unsigned VW = RW + 18;
  localparam int unsigned SN = (VW + 1) / 2;
  localparam int unsigned RadW = 2 * SN;
  localparam int unsigned RhoSt = 33 + SN;
  localparam int unsigned Last = RhoSt + 2;
  localparam int unsigned PW = SN + 31;
  localparam int unsigned Sh = 54 - OUT_FRAC_BITS;
  localparam int unsigned PhShL = (IN_FRAC_BITS <= 32) ? 32 - IN_FRAC_BITS : 0;
  localparam int unsigned PhShR = (IN_FRAC_BITS > 32) ? IN_FRAC_BITS - 32 : 0;

  logic                adv;
  logic [Last:0]       vld_q;
  bmg_pkg::side_t      side_d;
  bmg_pkg::side_t      side_q [Last];

  logic [31:0]         c1_in, c2_in, phase;
  logic [29:0]         r_in, rp_d;
  logic [31:0]         c1_q;
  logic [29:0]         rp_q;

  assign adv = !vld_q[Last] || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    c1_in = s_axis_tdata[31:0];
    c2_in = s_axis_tdata[63:32];
    phase = (c2_in << PhShL) >> PhShR;
    r_in = phase[29:0];
    side_d.bad = (c1_in == '0) || (c2_in == '0) ||
                 ((c1_in >> IN_FRAC_BITS) != '0) || ((c2_in >> IN_FRAC_BITS) != '0);
    side_d.quad = phase[31:30];
    side_d.swap = r_in > 30'h2000_0000;
    rp_d = side_d.swap ? 30'(31'h4000_0000 - 31'(r_in)) : r_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Last-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < Last; i++) side_q[i] <= side_q[i-1];
      c1_q <= c1_in;
      rp_q <= rp_d;
    end
  end

  // Logarithm row
  logic [4:0]     lead;
  logic [31:0]    norm;
  logic [30:0]    lm [bmg_pkg::LogSteps+1];
  logic [29:0]    lf [bmg_pkg::LogSteps+1];
  logic [HiW-1:0] le [bmg_pkg::LogSteps+1];
  logic [30:0]    lm0_q;
  logic [HiW-1:0] le0_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (c1_q[i]) lead = 5'(i);
    end
    norm = c1_q << (5'd31 - lead);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lm0_q <= norm[31:1];
      le0_q <= HiW'(IN_FRAC_BITS) - HiW'(lead);
    end
  end

  assign lm[0] = lm0_q;
  assign lf[0] = '0;
  assign le[0] = le0_q;

  for (genvar g = 0; g < bmg_pkg::LogSteps; g++) begin : g_log
    bmg_log_cell #(.EX_W(HiW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .m_i   (lm[g]),
      .frac_i(lf[g]),
      .ex_i  (le[g]),
      .m_o   (lm[g+1]),
      .frac_o(lf[g+1]),
      .ex_o  (le[g+1])
    );
  end

  logic [HiW+29:0] tlog;
  logic [60:0]     lo_prod;
  logic [HiW+30:0] ph_q;
  logic [30:0]     pl_q;
  logic [RW-1:0]   r_q;

  always_comb begin
    tlog = {le[bmg_pkg::LogSteps], 30'b0} - (HiW+30)'(lf[bmg_pkg::LogSteps]);
    lo_prod = 61'(tlog[29:0]) * 61'(bmg_pkg::TwoLn2Q30);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q <= (HiW+31)'(tlog[HiW+29:30]) * (HiW+31)'(bmg_pkg::TwoLn2Q30);
      pl_q <= lo_prod[60:30];
      r_q <= RW'(ph_q) + RW'(pl_q);
    end
  end

  // Square-root row
  logic [SN-1:0]   sroot [SN+1];
  logic [SN+1:0]   srem  [SN+1];
  logic [RadW-1:0] srad  [SN+1];

  assign sroot[0] = '0;
  assign srem[0] = '0;
  assign srad[0] = RadW'({r_q, 18'b0});

  for (genvar g = 0; g < SN; g++) begin : g_sqrt
    bmg_sqrt_cell #(.ROOT_W(SN)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .root_i(sroot[g]),
      .rem_i (srem[g]),
      .rad_i (srad[g]),
      .root_o(sroot[g+1]),
      .rem_o (srem[g+1]),
      .rad_o (srad[g+1])
    );
  end

  // Angle row
  logic [60:0]    xp, x2p, sp, cp;
  logic [29:0]    x_q;
  bmg_pkg::trig_t tr [bmg_pkg::TrigSteps+1];
  bmg_pkg::trig_t tr0_q;
  logic [29:0]    ps_q, pc_q;
  logic [30:0]    s0, k0;
  logic [30:0]    sn_q [12:RhoSt];
  logic [30:0]    cs_q [12:RhoSt];

  always_comb begin
    xp = 61'(rp_q) * 61'(bmg_pkg::HalfPiQ30);
    x2p = 61'(x_q) * 61'(x_q);
    sp = 61'(tr[bmg_pkg::TrigSteps].x) * 61'(tr[bmg_pkg::TrigSteps].ts);
    cp = 61'(tr[bmg_pkg::TrigSteps].x2) * 61'(tr[bmg_pkg::TrigSteps].tc);
    s0 = 31'(ps_q);
    k0 = bmg_pkg::Q30One - 31'(pc_q[29:1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= xp[59:30];
      tr0_q.x <= x_q;
      tr0_q.x2 <= x2p[59:30];
      tr0_q.ts <= bmg_pkg::Q30One;
      tr0_q.tc <= bmg_pkg::Q30One;
      ps_q <= sp[59:30];
      pc_q <= cp[59:30];
      sn_q[12] <= side_q[11].swap ? k0 : s0;
      cs_q[12] <= side_q[11].swap ? s0 : k0;
      for (int i = 13; i <= RhoSt; i++) begin
        sn_q[i] <= sn_q[i-1];
        cs_q[i] <= cs_q[i-1];
      end
    end
  end

  assign tr[0] = tr0_q;

  for (genvar g = 0; g < bmg_pkg::TrigSteps; g++) begin : g_trig
    bmg_trig_cell #(
      .RECIP_S(bmg_pkg::RecipSin[g]),
      .SHIFT_S(bmg_pkg::ShiftSin[g]),
      .RECIP_C(bmg_pkg::RecipCos[g]),
      .SHIFT_C(bmg_pkg::ShiftCos[g])
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .trig_i(tr[g]),
      .trig_o(tr[g+1])
    );
  end

  // Output scaling
  logic [PW-1:0] mc_q, ms_q;
  logic [1:0]    quad_o;
  logic          neg_cos, neg_sin;
  logic [31:0]   dout_q;
  logic          user_q;

  function automatic logic [15:0] to_out(input logic [PW-1:0] prod, input logic neg);
    logic [PW:0] sum;
    logic [PW:0] mag;
    logic [15:0] res;
    sum = {1'b0, prod} + ((PW+1)'(1) << (Sh - 1));
    mag = sum >> Sh;
    if (!neg) begin
      res = (mag > (PW+1)'(32767)) ? 16'h7fff : mag[15:0];
    end else begin
      res = (mag > (PW+1)'(32768)) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
    end
    return res;
  endfunction

  always_comb begin
    quad_o = side_q[RhoSt+1].quad;
    neg_cos = (quad_o == 2'd1) || (quad_o == 2'd2);
    neg_sin = quad_o[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mc_q <= PW'(sroot[SN]) * PW'(side_q[RhoSt].quad[0] ? sn_q[RhoSt] : cs_q[RhoSt]);
      ms_q <= PW'(sroot[SN]) * PW'(side_q[RhoSt].quad[0] ? cs_q[RhoSt] : sn_q[RhoSt]);
      if (side_q[RhoSt+1].bad) begin
        dout_q <= '0;
      end else begin
        dout_q <= {to_out(ms_q, neg_sin), to_out(mc_q, neg_cos)};
      end
      user_q <= side_q[RhoSt+1].bad;
    end
  end

  assign m_axis_tvalid = vld_q[Last];
  assign m_axis_tdata = dout_q;
  assign m_axis_tuser = user_q;

  `BMG_ASSERT(a_flag_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "flagged result carries data")
  `BMG_ASSERT(a_row_shift, clk_i, rst_ni, adv |=> vld_q[Last] == $past(vld_q[Last-1]), "valid row lost an item")
  `BMG_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid out of reset")

endmodule

FILE: sv/bmg_log_cell.sv
// One squaring step of the base-2 logarithm of the radius sample.
module bmg_log_cell #(
  parameter int unsigned EX_W = 6
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [30:0]     m_i,
  input  logic [29:0]     frac_i,
  input  logic [EX_W-1:0] ex_i,
  output logic [30:0]     m_o,
  output logic [29:0]     frac_o,
  output logic [EX_W-1:0] ex_o
);

  logic [61:0]     sq;
  logic [31:0]     sq_hi;
  logic [30:0]     m_d, m_q;
  logic [29:0]     frac_d, frac_q;
  logic [EX_W-1:0] ex_q;

  always_comb begin
    sq = 62'(m_i) * 62'(m_i);
    sq_hi = sq[61:30];
    if (sq_hi[31]) begin
      m_d = sq_hi[31:1];
      frac_d = {frac_i[28:0], 1'b1};
    end else begin
      m_d = sq_hi[30:0];
      frac_d = {frac_i[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
      frac_q <= frac_d;
      ex_q <= ex_i;
    end
  end

  assign m_o = m_q;
  assign frac_o = frac_q;
  assign ex_o = ex_q;

endmodule

FILE: sv/bmg_sqrt_cell.sv
// One result bit of the digit-by-digit integer square root.
module bmg_sqrt_cell #(
  parameter int unsigned ROOT_W = 28
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [ROOT_W+1:0]   rem_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  output logic [ROOT_W-1:0]   root_o,
  output logic [ROOT_W+1:0]   rem_o,
  output logic [2*ROOT_W-1:0] rad_o
);

  logic [ROOT_W+3:0]   rem_t, trial;
  logic [ROOT_W-1:0]   root_d, root_q;
  logic [ROOT_W+1:0]   rem_d, rem_q;
  logic [2*ROOT_W-1:0] rad_q;

  always_comb begin
    rem_t = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
    trial = (ROOT_W+4)'({root_i, 2'b01});
    if (rem_t >= trial) begin
      rem_d = (ROOT_W+2)'(rem_t - trial);
      root_d = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d = (ROOT_W+2)'(rem_t);
      root_d = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
      rem_q <= rem_d;
      rad_q <= {rad_i[2*ROOT_W-3:0], 2'b00};
    end
  end

  assign root_o = root_q;
  assign rem_o = rem_q;
  assign rad_o = rad_q;

endmodule

FILE: sv/bmg_trig_cell.sv
// One Horner step of the sine and cosine series, two register stages.
module bmg_trig_cell #(
  parameter logic [30:0] RECIP_S = 31'd1908874354,
  parameter int unsigned SHIFT_S = 37,
  parameter logic [30:0] RECIP_C = 31'd1527099483,
  parameter int unsigned SHIFT_C = 37
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  bmg_pkg::trig_t trig_i,
  output bmg_pkg::trig_t trig_o
);

  logic [60:0]    prod_s, prod_c, quo_s, quo_c;
  logic [29:0]    ps_q, pc_q;
  logic [29:0]    qs_q, qc_q;
  logic [29:0]    x_a_q, x2_a_q, x_b_q, x2_b_q;

  always_comb begin
    prod_s = 61'(trig_i.x2) * 61'(trig_i.ts);
    prod_c = 61'(trig_i.x2) * 61'(trig_i.tc);
    quo_s = (61'(ps_q) * 61'(RECIP_S)) >> SHIFT_S;
    quo_c = (61'(pc_q) * 61'(RECIP_C)) >> SHIFT_C;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps_q <= prod_s[59:30];
      pc_q <= prod_c[59:30];
      x_a_q <= trig_i.x;
      x2_a_q <= trig_i.x2;
      qs_q <= quo_s[29:0];
      qc_q <= quo_c[29:0];
      x_b_q <= x_a_q;
      x2_b_q <= x2_a_q;
    end
  end

  always_comb begin
    trig_o.x = x_b_q;
    trig_o.x2 = x2_b_q;
    trig_o.ts = bmg_pkg::Q30One - 31'(qs_q);
    trig_o.tc = bmg_pkg::Q30One - 31'(qc_q);
  end

endmodule

FILE: tb/box_muller_gaussian_tb.sv
// Testbench for the Box-Muller Gaussian pair generator: directed table, then random stream.
`timescale 1ns / 1ps

module box_muller_gaussian_tb;

  localparam int unsigned InFracBits = 32;
  localparam int unsigned OutFracBits = 12;
  localparam int unsigned NumRandom = 1430;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned Latency = 63;

  typedef struct packed {
    logic [15:0] gauss_cos;
    logic [15:0] gauss_sin;
    logic        out_of_range;
  } gauss_pair_t;

  typedef struct {
    logic [31:0] u_radius;
    logic [31:0] u_angle;
    bit          fixed;
    gauss_pair_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  gauss_pair_t pending_pairs[$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_sent;
  int unsigned n_bad;
  int unsigned idle_cycles;
  bit          stim_done;
  bit          hold_off;

  box_muller_gaussian #(
    .IN_FRAC_BITS (InFracBits),
    .OUT_FRAC_BITS(OutFracBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] minus_two_ln(logic [63:0] c);
    int unsigned p;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] t;
    p = 0;
    frac = '0;
    while (p < 63 && (c >> (p + 1)) != 0) p++;
    m = (p >= 30) ? (c >> (p - 30)) : (c << (30 - p));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    t = (64'(InFracBits - p) << 30) - frac;
    return (t >> 30) * 64'd1488522236 + (((t & 64'h3FFF_FFFF) * 64'd1488522236) >> 30);
  endfunction

  function automatic logic [15:0] round_to_out(logic [63:0] rho, logic [63:0] trig, bit neg);
    int unsigned sh;
    logic [63:0] mag;
    sh = 54 - OutFracBits;
    mag = (rho * trig + (64'd1 << (sh - 1))) >> sh;
    if (!neg) return (mag > 64'd32767) ? 16'd32767 : mag[15:0];
    if (mag > 64'd32768) mag = 64'd32768;
    return 16'(64'd0 - mag);
  endfunction

  function automatic gauss_pair_t predict_pair(logic [31:0] c1, logic [31:0] c2);
    gauss_pair_t res;
    logic [63:0] one, rho, phase, r, x, x2, t, s0, k0, sn, cs;
    logic [1:0]  quad;
    bit          swap;
    one = 64'd1 << 30;
    res = '0;
    if (c1 == 0 || c2 == 0) begin
      res.out_of_range = 1'b1;
      return res;
    end
    rho = int_sqrt(minus_two_ln(64'(c1)) << 18);
    phase = 64'(c2);
    quad = phase[31:30];
    r = phase & (one - 1);
    swap = r > (one >> 1);
    if (swap) r = one - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = one - ((x2 * one) >> 30) / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s0 = (x * t) >> 30;
    t = one - ((x2 * one) >> 30) / 90;
    t = one - ((x2 * t) >> 30) / 56;
    t = one - ((x2 * t) >> 30) / 30;
    t = one - ((x2 * t) >> 30) / 12;
    k0 = one - ((x2 * t) >> 30) / 2;
    sn = swap ? k0 : s0;
    cs = swap ? s0 : k0;
    case (quad)
      2'd0: begin
        res.gauss_cos = round_to_out(rho, cs, 0);
        res.gauss_sin = round_to_out(rho, sn, 0);
      end
      2'd1: begin
        res.gauss_cos = round_to_out(rho, sn, 1);
        res.gauss_sin = round_to_out(rho, cs, 0);
      end
      2'd2: begin
        res.gauss_cos = round_to_out(rho, cs, 1);
        res.gauss_sin = round_to_out(rho, sn, 1);
      end
      default: begin
        res.gauss_cos = round_to_out(rho, sn, 0);
        res.gauss_sin = round_to_out(rho, cs, 1);
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom_range(1, 255);
      4:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      5:       return {2'($urandom_range(0, 3)), 30'h2000_0000 + 30'($urandom_range(0, 3)) - 30'd1};
      default: return $urandom();
    endcase
  endfunction

  // Send one transfer; tvalid stays high into the next transfer when no gap follows.
  task automatic send_pair(logic [31:0] c1, logic [31:0] c2, int unsigned gap);
    s_axis_tdata <= {c2, c1};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pairs.push_back(predict_pair(c1, c2));
    n_sent++;
    if (c1 == 0 || c2 == 0) n_bad++;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  stim_row_t directed[$];

  initial begin
    directed = '{
      '{32'd0,          32'd0,          1, '{16'd0, 16'd0, 1'b1}},
      '{32'd0,          32'h8000_0000,  1, '{16'd0, 16'd0, 1'b1}},
      '{32'h8000_0000,  32'd0,          1, '{16'd0, 16'd0, 1'b1}},
      '{32'hFFFF_FFFF,  32'd0,          1, '{16'd0, 16'd0, 1'b1}},
      '{32'd1,          32'd1,          0, '0},
      '{32'd1,          32'hFFFF_FFFF,  0, '0},
      '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  0, '0},
      '{32'hFFFF_FFFF,  32'd1,          0, '0},
      '{32'h8000_0000,  32'h4000_0000,  0, '0},
      '{32'h8000_0000,  32'h8000_0000,  0, '0},
      '{32'h8000_0000,  32'hC000_0000,  0, '0},
      '{32'h0000_0100,  32'h2000_0000,  0, '0},
      '{32'h0000_0100,  32'h2000_0001,  0, '0},
      '{32'h1234_5678,  32'h6000_0001,  0, '0},
      '{32'h5555_5555,  32'hAAAA_AAAA,  0, '0},
      '{32'hAAAA_AAAA,  32'h5555_5555,  0, '0},
      '{32'h0000_0002,  32'hE000_0000,  0, '0},
      '{32'h4000_0000,  32'h1FFF_FFFF,  0, '0}
    };
  end

  initial begin
    int unsigned gap;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    stim_done = 1'b0;
    n_sent = 0;
    n_bad = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      send_pair(directed[i].u_radius, directed[i].u_angle, gap_len());
      if (directed[i].fixed) pending_pairs[$] = directed[i].want;
    end
    for (int i = 0; i < NumRandom; i++) begin
      gap = (i >= 300 && i < 400) ? 0 : gap_len();
      send_pair(pick_sample(), pick_sample(), gap);
      if (i == 700) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_pairs.size() == 0);
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls; one long hold-off lets the pipeline fill and push back.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    hold_off = 1'b0;
    wait (rst_ni);
    while (n_sent < 320) begin
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      stall = gap_len();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
    m_axis_tready <= 1'b0;
    hold_off = 1'b1;
    repeat (200) @(negedge clk_i);
    hold_off = 1'b0;
    forever begin
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      stall = gap_len();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    gauss_pair_t got;
    gauss_pair_t want;
    if (m_axis_tvalid && m_axis_tready && rst_ni) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
      n_results++;
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        n_errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (got.gauss_cos !== want.gauss_cos)
          begin $display("%0t: gauss_cos expected %h actual %h", $realtime,
                         want.gauss_cos, got.gauss_cos); n_errors++; end
        if (got.gauss_sin !== want.gauss_sin)
          begin $display("%0t: gauss_sin expected %h actual %h", $realtime,
                         want.gauss_sin, got.gauss_sin); n_errors++; end
        if (got.out_of_range !== want.out_of_range)
          begin $display("%0t: out_of_range expected %b actual %b", $realtime,
                         want.out_of_range, got.out_of_range); n_errors++; end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    n_errors = 0;
    n_results = 0;
    idle_cycles = 0;
    fork
      begin
        wait (stim_done && pending_pairs.size() == 0);
        repeat (Latency + 20) @(posedge clk_i);
      end
      wait (idle_cycles >= WatchdogLimit);
    join_any
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_pairs.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      if (pending_pairs.size() != 0) n_errors++;
      $display("Sent %0d sample pairs (%0d with a zero sample), checked %0d results,",
               n_sent, n_bad, n_results);
      $display("with random gaps on both sides and a long output stall; %0d errors",
               n_errors);
      if (n_errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/bmg_pkg.sv
sv/bmg_log_cell.sv
sv/bmg_sqrt_cell.sv
sv/bmg_trig_cell.sv
sv/box_muller_gaussian.sv
tb/box_muller_gaussian_tb.sv
